>>> hdl/bdc_pkg.sv
// Shared types and constants for the baud divisor calculator.
// No dependencies; compiled first.
package bdc_pkg;

   // Field widths
   localparam int BAUD_W  = 23;
   localparam int CLOCK_W = 28;
   localparam int WORD_W  = 16;
   localparam int MANT_W  = 12;

   // Divider datapath widths: dividend 25*clock, divisor 100*k*baud
   localparam int DVD_W  = 33;
   localparam int DVS_W  = 32;
   localparam int DEN_W  = 25;
   localparam int STEP_W = 6;

   // Iteration counts for the two divide passes
   localparam logic [STEP_W-1:0] STEPS_MANT = 6'd33;
   localparam logic [STEP_W-1:0] STEPS_REM  = 6'd7;

   // Reset values
   localparam logic [BAUD_W-1:0]  BAUD_RESET  = 23'd115200;
   localparam logic [CLOCK_W-1:0] CLOCK_RESET = 28'd84000000;

   // Fraction rounding: (x + 50) / 100 via reciprocal 1311 / 2^17, exact for x < 1650
   localparam logic [10:0] ROUND_HALF = 11'd50;
   localparam logic [10:0] FRAC_RECIP = 11'd1311;
   localparam int          FRAC_SHIFT = 17;

   // Register indexes on the csr channel
   localparam logic CSR_BUS_CLOCK  = 1'b0;
   localparam logic CSR_OVERSAMPLE = 1'b1;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV1 = 4'b0010,
      ST_DIV2 = 4'b0100,
      ST_OUT  = 4'b1000
   } bdc_state_type;

   // Commands to and status from the shared divider
   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } bdc_div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bdc_div_sts_type;

endpackage

>>> hdl/bdc_if.sv
// Valid/ready channel interfaces for request, response and csr writes.
// Depends on bdc_pkg for field widths.
interface bdc_req_if import bdc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BAUD_W-1:0] requested_baud;

   modport source (output valid, output requested_baud, input ready);
   modport sink   (input valid, input requested_baud, output ready);
endinterface

interface bdc_rsp_if import bdc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] divisor_word;

   modport source (output valid, output divisor_word, input ready);
   modport sink   (input valid, input divisor_word, output ready);
endinterface

interface bdc_csr_if import bdc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               index;
   logic [CLOCK_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/bdc_div_unit.sv
// Shared restoring divider: one quotient bit per cycle for a given step count.
// Depends on bdc_pkg for widths and the command/status structs.
module bdc_div_unit import bdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  bdc_div_cmd_type   cmd,
   input  logic [DVS_W-1:0]  rem_init,
   input  logic [DVD_W-1:0]  dvd_init,
   input  logic [DVS_W-1:0]  dvs,
   output bdc_div_sts_type   sts,
   output logic [DVS_W-1:0]  rem,
   output logic [DVD_W-1:0]  quo
);

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              done_ff, done_in;

   logic [DVS_W:0] trial;
   logic           fits;

   // One restoring step: shift in next dividend bit, subtract if it fits
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         rem_in   = rem_init;
         dvd_in   = dvd_init;
         dvs_in   = dvs;
         count_in = cmd.steps;
      end else if (count_ff != '0) begin
         rem_in   = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         dvd_in   = {dvd_ff[DVD_W-2:0], fits};
         count_in = count_ff - STEP_W'(1);
         done_in  = (count_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   assign sts.busy = (count_ff != '0);
   assign sts.done = done_ff;
   assign rem      = rem_ff;
   assign quo      = dvd_ff;

endmodule

>>> hdl/uart_baud_divisor_calc.sv
// Top level of the UART fractional baud divisor calculator.
// Depends on bdc_pkg, the bdc_*_if interfaces and bdc_div_unit.
//
//   port    | dir  | transfer carries
//   --------+------+-------------------------------------------
//   req_ch  | sink | requested_baud (0 keeps the stored rate)
//   rsp_ch  | src  | divisor_word
//   csr_ch  | sink | index 0 bus_clock_hz, index 1 oversample_by_eight
//
// After a request transfer a setup step starts the mantissa pass on the shared
// divider (25*clock / (100*k*baud)); the block then loads the remainder pass,
// runs it for the remainder digit and forms the word before response valid.
// req_ch.ready is low until the response transfer completes, and a stalled
// response simply holds.
// Reset restores 84 MHz bus clock, 16x oversampling and 115200 baud.
// csr_ch is always ready.
module uart_baud_divisor_calc import bdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   bdc_req_if.sink   req_ch,
   bdc_rsp_if.source rsp_ch,
   bdc_csr_if.sink   csr_ch
);

   bdc_state_type state_ff, state_in;

   logic [CLOCK_W-1:0] clock_hz_ff, clock_hz_in;
   logic               os8_ff, os8_in;
   logic [BAUD_W-1:0]  baud_ff, baud_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [MANT_W-1:0]  mant_ff, mant_in;
   logic [WORD_W-1:0]  word_ff, word_in;

   bdc_div_cmd_type  div_cmd;
   bdc_div_sts_type  div_sts;
   logic [DVS_W-1:0] div_rem_init, div_rem;
   logic [DVD_W-1:0] div_dvd_init, div_quo;
   logic [DVS_W-1:0] div_dvs;

   logic [DVD_W-1:0] num;
   logic [DEN_W-1:0] den;
   logic [DVS_W-1:0] den100;
   logic [10:0]      round_x;
   logic [21:0]      round_prod;
   logic [4:0]       frac_raw;
   logic [3:0]       frac;

   // Setup arithmetic: 25*clock and k*baud, 100*k*baud as shift-adds
   assign num    = {1'b0, clock_hz_ff, 4'b0} + {2'b0, clock_hz_ff, 3'b0} + DVD_W'(clock_hz_ff);
   assign den    = os8_ff ? {1'b0, baud_ff, 1'b0} : {baud_ff, 2'b0};
   assign den100 = {1'b0, den, 6'b0} + {2'b0, den, 5'b0} + {5'b0, den, 2'b0};

   // Fraction rounding on the 7-bit remainder digit
   assign round_x    = (os8_ff ? {1'b0, div_quo[6:0], 3'b0} : {div_quo[6:0], 4'b0})
                       + ROUND_HALF;
   assign round_prod = 22'(round_x) * 22'(FRAC_RECIP);
   assign frac_raw   = round_prod[21:FRAC_SHIFT];
   assign frac       = os8_ff ? {1'b0, frac_raw[2:0]} : frac_raw[3:0];

   // Sequencer and divider command
   always_comb begin
      state_in     = state_ff;
      baud_in      = baud_ff;
      den_in       = den_ff;
      mant_in      = mant_ff;
      word_in      = word_ff;
      div_cmd      = '0;
      div_rem_init = '0;
      div_dvd_init = num;
      div_dvs      = den100;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.requested_baud != '0) begin
                  baud_in = req_ch.requested_baud;
               end
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            // first cycle here loads the mantissa pass
            if (!div_sts.busy && !div_sts.done) begin
               div_cmd.start = 1'b1;
               div_cmd.steps = STEPS_MANT;
               den_in        = den;
            end else if (div_sts.done) begin
               // remainder < 100*den: 7 quotient bits give the percent digit
               mant_in       = div_quo[MANT_W-1:0];
               div_cmd.start = 1'b1;
               div_cmd.steps = STEPS_REM;
               div_rem_init  = DVS_W'(div_rem[DVS_W-1:7]);
               div_dvd_init  = {div_rem[6:0], 26'b0};
               div_dvs       = DVS_W'(den_ff);
               state_in      = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_sts.done) begin
               word_in  = {mant_ff, frac};
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Configuration writes
   always_comb begin
      clock_hz_in = clock_hz_ff;
      os8_in      = os8_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_BUS_CLOCK:  clock_hz_in = csr_ch.data;
            CSR_OVERSAMPLE: os8_in      = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      mant_ff <= mant_in;
      word_ff <= word_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         clock_hz_ff <= CLOCK_RESET;
         os8_ff      <= 1'b0;
         baud_ff     <= BAUD_RESET;
      end else begin
         state_ff    <= state_in;
         clock_hz_ff <= clock_hz_in;
         os8_ff      <= os8_in;
         baud_ff     <= baud_in;
      end
   end

   bdc_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .rem_init (div_rem_init),
      .dvd_init (div_dvd_init),
      .dvs      (div_dvs),
      .sts      (div_sts),
      .rem      (div_rem),
      .quo      (div_quo)
   );

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = (state_ff == ST_OUT);
   assign rsp_ch.divisor_word = word_ff;
   assign csr_ch.ready        = 1'b1;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for uart_baud_divisor_calc: directed and random baud
// requests under several bus clock / oversampling settings, checked by a scoreboard.
// Depends on bdc_pkg, the bdc_*_if interfaces and the uart_baud_divisor_calc RTL.
`timescale 1ns / 1ps

// Tracks the block's settings and stored rate, predicts each divisor word
class divisor_scoreboard;
   localparam longint unsigned CLOCK_SCALE = 25;
   localparam longint unsigned PERCENT     = 100;
   localparam longint unsigned ROUND_HALF  = 50;
   localparam longint unsigned MASK_8X     = 'h07;
   localparam longint unsigned MASK_16X    = 'h0F;

   typedef struct {
      bit [bdc_pkg::BAUD_W-1:0] baud;
      bit [bdc_pkg::WORD_W-1:0] word;
   } pending_word_type;

   bit [bdc_pkg::CLOCK_W-1:0] bus_clock;
   bit                        oversample_8x;
   bit [bdc_pkg::BAUD_W-1:0]  stored_baud;
   pending_word_type          pending_words[$];
   int                        errors;

   function new();
      bus_clock     = bdc_pkg::CLOCK_RESET;
      oversample_8x = 1'b0;
      stored_baud   = bdc_pkg::BAUD_RESET;
      errors        = 0;
   endfunction

   function void apply_register(logic idx, logic [bdc_pkg::CLOCK_W-1:0] value);
      if (idx == bdc_pkg::CSR_BUS_CLOCK)
         bus_clock = value;
      else
         oversample_8x = value[0];
   endfunction

   // 25*clock / (k*baud), split into mantissa and rounded fraction
   function bit [bdc_pkg::WORD_W-1:0] divisor_for_rate();
      longint unsigned num, den, quot, mant, rem, frac;
      num  = CLOCK_SCALE * longint'(bus_clock);
      den  = longint'(stored_baud) * (oversample_8x ? 64'd2 : 64'd4);
      quot = (den == 0) ? 64'd0 : num / den;
      mant = quot / PERCENT;
      rem  = quot - PERCENT * mant;
      // carry out of the fraction is masked away, never added to the mantissa
      if (oversample_8x)
         frac = ((rem * 8 + ROUND_HALF) / PERCENT) & MASK_8X;
      else
         frac = ((rem * 16 + ROUND_HALF) / PERCENT) & MASK_16X;
      return bdc_pkg::WORD_W'((mant << 4) | frac);
   endfunction

   function void note_request(bit [bdc_pkg::BAUD_W-1:0] baud);
      pending_word_type entry;
      if (baud != 0)
         stored_baud = baud;
      entry.baud = baud;
      entry.word = divisor_for_rate();
      pending_words.push_back(entry);
   endfunction

   function void check_word(bit [bdc_pkg::WORD_W-1:0] word);
      pending_word_type entry;
      if (pending_words.size() == 0) begin
         $display("%0t: unexpected divisor_word transfer, actual 0x%04h", $time, word);
         errors++;
         return;
      end
      entry = pending_words.pop_front();
      if (entry.word !== word) begin
         $display("%0t: divisor_word mismatch (baud %0d), expected 0x%04h, actual 0x%04h",
                  $time, entry.baud, entry.word, word);
         errors++;
      end
   endfunction

   function int outstanding();
      return pending_words.size();
   endfunction

   function bit all_clear();
      foreach (pending_words[i])
         $display("%0t: divisor_word never seen (baud %0d), expected 0x%04h",
                  $time, pending_words[i].baud, pending_words[i].word);
      return (errors == 0) && (pending_words.size() == 0);
   endfunction
endclass

module testbench;
   import bdc_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AT_WORD  = 150;
   localparam int SETTLE_CYCLES = 60;
   localparam int RANDOM_PHASES = 16;
   localparam int PHASE_ITEMS   = 100;

   logic clock;
   logic reset;

   bdc_req_if req_ch ();
   bdc_rsp_if rsp_ch ();
   bdc_csr_if csr_ch ();

   divisor_scoreboard sb;
   bit                bursts_enabled = 1'b1;
   bit                hold_done      = 1'b0;
   int                words_checked  = 0;
   int                idle_cycles    = 0;

   bit [BAUD_W-1:0]  common_rates [8] = '{300, 1200, 9600, 19200, 38400, 57600,
                                          115200, 921600};
   bit [CLOCK_W-1:0] common_clocks[6] = '{8000000, 16000000, 42000000, 48000000,
                                          84000000, 180000000};

   uart_baud_divisor_calc i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Request channel: optional idle burst, then hold until transfer
   task automatic send_request(input bit [BAUD_W-1:0] baud);
      @(negedge clock);
      if (bursts_enabled && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.requested_baud <= baud;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_request(baud);
   endtask

   task automatic end_requests();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic write_csr(input logic idx, input logic [CLOCK_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      sb.apply_register(idx, value);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Settings change only once the block has returned every word
   task automatic apply_settings(input logic [CLOCK_W-1:0] bus_hz, input bit ovs_8x);
      wait_drained();
      write_csr(CSR_BUS_CLOCK, bus_hz);
      write_csr(CSR_OVERSAMPLE, CLOCK_W'(ovs_8x));
   endtask

   function automatic bit [BAUD_W-1:0] pick_baud();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return common_rates[$urandom_range(0, 7)];
         2, 3, 4: return BAUD_W'($urandom_range(1, 1000));
         5:       return BAUD_W'($urandom());
         default: return BAUD_W'($urandom_range(1, 7500000));
      endcase
   endfunction

   function automatic bit [CLOCK_W-1:0] pick_bus_clock();
      case ($urandom_range(0, 4))
         0, 1:    return common_clocks[$urandom_range(0, 5)];
         2:       return CLOCK_W'($urandom_range(1, 171798691));
         3:       return CLOCK_W'($urandom());
         default: return CLOCK_W'($urandom_range(1, 1000));
      endcase
   endfunction

   // Response channel: random stalls, one long hold-off to back up the input
   initial begin
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!hold_done && words_checked >= HOLD_AT_WORD) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (bursts_enabled && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_word(rsp_ch.divisor_word);
         words_checked++;
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("uart_baud_divisor_calc regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence
   initial begin
      sb = new();
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.requested_baud <= '0;
      csr_ch.valid          <= 1'b0;
      csr_ch.index          <= CSR_BUS_CLOCK;
      csr_ch.data           <= '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: zero reuses 115200, field extremes, 16x fraction carry
      send_request(0);
      send_request(1);
      send_request(23'h7FFFFF);
      send_request(7500000);
      send_request(0);
      send_request(115200);
      send_request(9600);
      send_request(2664974);
      end_requests();

      // 8x oversampling at 84 MHz, with an 8x fraction carry
      apply_settings(84000000, 1'b1);
      send_request(5329949);
      send_request(0);
      send_request(1);
      send_request(7500000);
      end_requests();

      // Largest bus clock the field holds, wide mantissa truncation
      apply_settings({CLOCK_W{1'b1}}, 1'b0);
      send_request(1);
      send_request(23'h7FFFFF);
      send_request(300);
      end_requests();

      apply_settings(171798691, 1'b1);
      send_request(1);
      send_request(7500000);
      end_requests();

      apply_settings(1, 1'b0);
      send_request(1);
      send_request(2);
      end_requests();

      apply_settings(0, 1'b1);
      send_request(0);
      send_request(57600);
      end_requests();

      // Random phases, each under a new setting; last phase runs without stalls
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1)
            bursts_enabled = 1'b0;
         apply_settings(pick_bus_clock(), 1'($urandom_range(0, 1)));
         repeat (PHASE_ITEMS) send_request(pick_baud());
         end_requests();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.all_clear())
         $display("uart_baud_divisor_calc regression: pass");
      else
         $display("uart_baud_divisor_calc regression: fail");
      $finish;
   end

endmodule
